// File: sv/bclru_pkg.sv
// shared types and codes for the buffer cache lru tag manager
// no dependencies; imported by the controller, the datapath and the top level
package bclru_pkg;

	// field widths fixed by the request and result formats
	localparam int BLOCK_W  = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_F_W = 3;
	localparam int COUNT_W  = 4;

	// request codes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NONE   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RDFAIL = 3'd4;
	localparam logic [STATUS_W-1:0] ST_REL    = 3'd5;
	localparam logic [STATUS_W-1:0] ST_BADREL = 3'd6;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;     // capture a request
		logic compare;  // register the tag match vector
		logic update;   // apply the request and register the result
	} bclru_cmd_t;

endpackage

// File: sv/buffer_cache_lru_tag_manager.sv
// a request taken from idle passes the tag compare stage and then the free-list update
//   stage, where the result registers load; done is registered from the update stage
// a new request can be taken while the last is in the free-list update stage, so only
//   the compare stage holds requests off; busy is high only during the compare cycle
// reset (arst_n low): all tags zero, no slot valid or locked, free list holds every slot
//   in slot order; the receiver cannot stall; done is high for one cycle per result
module buffer_cache_lru_tag_manager #(
	parameter int POOL_SLOTS        = 8,
	parameter int BLOCK_NUMBER_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [bclru_pkg::BLOCK_W-1:0]  block_number,
	input  logic [bclru_pkg::SLOT_F_W-1:0] slot,
	input  logic                           read_ok,
	output logic                           done,
	output logic [bclru_pkg::STATUS_W-1:0] status,
	output logic [bclru_pkg::SLOT_F_W-1:0] slot_used,
	output logic                           contents_valid,
	output logic [bclru_pkg::COUNT_W-1:0]  free_count
);
	import bclru_pkg::*;

	bclru_cmd_t cmd;

	// controller: idle -> compare -> update, with a new transfer allowed in update
	bclru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// datapath: per-slot tags and marks, the lru free list and the result registers
	bclru_datapath #(
		.POOL_SLOTS        (POOL_SLOTS),
		.BLOCK_NUMBER_BITS (BLOCK_NUMBER_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.op             (op),
		.block_number   (block_number),
		.slot           (slot),
		.read_ok        (read_ok),
		.status         (status),
		.slot_used      (slot_used),
		.contents_valid (contents_valid),
		.free_count     (free_count)
	);

	// every accepted transfer yields its result transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result missing three edges after an accepted request");

	// the compare state never follows itself, so busy always drops after the compare state
	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	// a get that found nothing free must see an empty free list and report slot zero
	a_none_free: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NONE) |-> (free_count == '0 && slot_used == '0 && !contents_valid))
		else $error("none-free result with a non-empty free list");

	// a successful miss always leaves the retagged slot valid
	a_miss_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_MISS) |-> contents_valid)
		else $error("miss loaded without a valid mark");

endmodule

// File: sv/bclru_ctrl.sv
// sequencing controller for the buffer cache lru tag manager
// depends on bclru_pkg for the command struct
module bclru_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output bclru_pkg::bclru_cmd_t cmd
);
	import bclru_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   done_q;
	logic   accept;

	assign busy   = (state_q == S_CMP);
	assign accept = start && !busy;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = S_CMP;
			end
			S_CMP: begin
				state_nxt = S_UPD;
			end
			S_UPD: begin
				// a new request may enter while this one completes
				state_nxt = accept ? S_CMP : S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == S_UPD);
		end
	end

	assign cmd.load    = accept;
	assign cmd.compare = (state_q == S_CMP);
	assign cmd.update  = (state_q == S_UPD);
	assign done        = done_q;

endmodule

// File: sv/bclru_datapath.sv
// tag store, lock and valid marks, ordered free list and result registers
// depends on bclru_pkg for codes, widths and the command struct
module bclru_datapath #(
	parameter int POOL_SLOTS        = 8,
	parameter int BLOCK_NUMBER_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bclru_pkg::bclru_cmd_t             cmd,
	input  logic                              op,
	input  logic [bclru_pkg::BLOCK_W-1:0]     block_number,
	input  logic [bclru_pkg::SLOT_F_W-1:0]    slot,
	input  logic                              read_ok,
	output logic [bclru_pkg::STATUS_W-1:0]    status,
	output logic [bclru_pkg::SLOT_F_W-1:0]    slot_used,
	output logic                              contents_valid,
	output logic [bclru_pkg::COUNT_W-1:0]     free_count
);
	import bclru_pkg::*;

	localparam int SLOT_W = $clog2(POOL_SLOTS);
	localparam int LEN_W  = $clog2(POOL_SLOTS + 1);
	localparam int TAG_W  = (BLOCK_NUMBER_BITS < BLOCK_W) ? BLOCK_NUMBER_BITS : BLOCK_W;

	// captured request
	logic                op_q;
	logic [TAG_W-1:0]    blk_q;
	logic [SLOT_F_W-1:0] rel_q;
	logic                rd_ok_q;

	// per-slot state
	logic [TAG_W-1:0]      tag_q   [POOL_SLOTS];
	logic [POOL_SLOTS-1:0] valid_q;
	logic [POOL_SLOTS-1:0] lock_q;
	logic [SLOT_W-1:0]     order_q [POOL_SLOTS];
	logic [LEN_W-1:0]      len_q;

	logic [POOL_SLOTS-1:0] match_s1;

	// result registers
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_F_W-1:0] used_q;
	logic                cv_q;
	logic [COUNT_W-1:0]  count_q;

	// update decision
	logic                hit_any;
	logic [SLOT_W-1:0]   hit_slot;
	logic [SLOT_W-1:0]   rel_idx;
	logic                rel_ok;
	logic [SLOT_W-1:0]   sel;
	logic                rm_en;
	logic                ap_en;
	logic                lock_set;
	logic                lock_clr;
	logic                tag_we;
	logic [STATUS_W-1:0] st_nxt;
	logic [SLOT_F_W-1:0] used_nxt;
	logic                cv_nxt;

	// free list update
	logic [SLOT_W-1:0] shifted [POOL_SLOTS];
	logic [SLOT_W-1:0] order_nxt [POOL_SLOTS];
	logic [LEN_W-1:0]  len_rm;
	logic [LEN_W-1:0]  len_nxt;

	assign rel_idx = SLOT_W'(rel_q);
	assign rel_ok  = ({29'd0, rel_q} < 32'(POOL_SLOTS));

	// first matching slot in slot order
	always_comb begin
		hit_any  = 1'b0;
		hit_slot = '0;
		for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				hit_any  = 1'b1;
				hit_slot = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		sel      = order_q[0];
		rm_en    = 1'b0;
		ap_en    = 1'b0;
		lock_set = 1'b0;
		lock_clr = 1'b0;
		tag_we   = 1'b0;
		st_nxt   = ST_NONE;
		used_nxt = '0;
		cv_nxt   = 1'b0;
		if (op_q == OP_PUT) begin
			sel      = rel_idx;
			used_nxt = rel_q;
			if (!rel_ok) begin
				st_nxt = ST_BADREL;
			end else if (!lock_q[rel_idx]) begin
				st_nxt = ST_BADREL;
				cv_nxt = valid_q[rel_idx];
			end else begin
				st_nxt   = ST_REL;
				lock_clr = 1'b1;
				ap_en    = 1'b1;
				cv_nxt   = valid_q[rel_idx];
			end
		end else if (hit_any) begin
			sel      = hit_slot;
			used_nxt = SLOT_F_W'(hit_slot);
			cv_nxt   = valid_q[hit_slot];
			if (lock_q[hit_slot]) begin
				st_nxt = ST_BUSY;
			end else begin
				st_nxt   = ST_HIT;
				rm_en    = 1'b1;
				lock_set = 1'b1;
			end
		end else if (len_q != '0) begin
			// miss: retag the least recently released slot
			sel      = order_q[0];
			used_nxt = SLOT_F_W'(order_q[0]);
			rm_en    = 1'b1;
			tag_we   = 1'b1;
			cv_nxt   = rd_ok_q;
			if (rd_ok_q) begin
				st_nxt   = ST_MISS;
				lock_set = 1'b1;
			end else begin
				st_nxt = ST_RDFAIL;
				ap_en  = 1'b1;
			end
		end
	end

	// remove sel from wherever it stands, then optionally append it at the tail
	always_comb begin
		logic seen;
		logic pos_hit;
		seen = 1'b0;
		for (int j = 0; j < POOL_SLOTS; j++) begin
			pos_hit = (LEN_W'(j) < len_q) && (order_q[j] == sel);
			seen    = seen | pos_hit;
			if (rm_en && seen && (j != POOL_SLOTS - 1)) begin
				shifted[j] = order_q[(j + 1) % POOL_SLOTS];
			end else begin
				shifted[j] = order_q[j];
			end
		end
	end

	assign len_rm  = len_q - LEN_W'(rm_en);
	assign len_nxt = len_rm + LEN_W'(ap_en);

	always_comb begin
		for (int j = 0; j < POOL_SLOTS; j++) begin
			if (ap_en && (LEN_W'(j) == len_rm)) begin
				order_nxt[j] = sel;
			end else begin
				order_nxt[j] = shifted[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			lock_q  <= '0;
			len_q   <= LEN_W'(POOL_SLOTS);
			for (int i = 0; i < POOL_SLOTS; i++) begin
				tag_q[i]   <= '0;
				order_q[i] <= SLOT_W'(i);
			end
		end else if (cmd.update) begin
			if (tag_we) begin
				tag_q[sel]   <= blk_q;
				valid_q[sel] <= rd_ok_q;
			end
			if (lock_set) lock_q[sel] <= 1'b1;
			if (lock_clr) lock_q[sel] <= 1'b0;
			order_q <= order_nxt;
			len_q   <= len_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			blk_q   <= block_number[TAG_W-1:0];
			rel_q   <= slot;
			rd_ok_q <= read_ok;
		end
		if (cmd.compare) begin
			for (int i = 0; i < POOL_SLOTS; i++) begin
				match_s1[i] <= (tag_q[i] == blk_q);
			end
		end
		if (cmd.update) begin
			status_q <= st_nxt;
			used_q   <= used_nxt;
			cv_q     <= cv_nxt;
			count_q  <= COUNT_W'(len_nxt);
		end
	end

	assign status         = status_q;
	assign slot_used      = used_q;
	assign contents_valid = cv_q;
	assign free_count     = count_q;

endmodule
